### hw/rtl/axd_pkg.sv
// ----------------------------------------------------------------------------
// Audio xorshift dither package
// Shared types, register indexes, reset values and the xorshift32 step.
// ----------------------------------------------------------------------------
package axd_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam int XS_SHIFT_A = 13;
    localparam int XS_SHIFT_B = 17;
    localparam int XS_SHIFT_C = 5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_SCALE           = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_LENGTH    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SEED_LOW_LANES  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SEED_HIGH_LANES = 3'd4;

    localparam logic [31:0] RESET_SCALE         = 32'd0;
    localparam logic [10:0] RESET_TABLE_LENGTH  = 11'd1024;
    localparam logic [6:0]  RESET_CHANNEL_COUNT = 7'd2;
    localparam logic [31:0] RESET_LANE_WORD     = 32'd1;

    localparam logic [6:0] MAX_CHANNELS = 7'd64;

    localparam logic KIND_BLOCK_START = 1'b0;
    localparam logic KIND_SAMPLE      = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] block_length;
        logic [31:0] sample;
    } in_payload_t;

    typedef struct packed {
        logic [31:0] dithered_sample;
        logic        last_of_block;
        logic        outside_block;
    } out_payload_t;

    typedef struct packed {
        logic       step;
        logic [1:0] lane;
    } noise_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_DRAIN
    } state_t;

    function automatic logic [31:0] xs32(input logic [31:0] w);
        logic [31:0] t;
        t = w ^ (w << XS_SHIFT_A);
        t = t ^ (t >> XS_SHIFT_B);
        t = t ^ (t << XS_SHIFT_C);
        return t;
    endfunction

endpackage

### hw/rtl/axd_stream_if.sv
// ----------------------------------------------------------------------------
// Audio xorshift dither stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface axd_in_if import axd_pkg::*; ();
    logic        valid;
    logic        ready;
    in_payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface axd_out_if import axd_pkg::*; ();
    logic         valid;
    logic         ready;
    out_payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/axd_table_mem.sv
// ----------------------------------------------------------------------------
// Dither table memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module axd_table_mem import axd_pkg::*; #(
    parameter int DEPTH = DEFAULT_TABLE_DEPTH,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [31:0]      wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [31:0]      rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/axd_noise_gen.sv
// ----------------------------------------------------------------------------
// Dither noise generator
// Four xorshift32 lanes and the scaling multiplier, one entry per step.
// ----------------------------------------------------------------------------
module axd_noise_gen import axd_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [31:0]            scale,
    input  noise_ctrl_t            ctrl,
    output logic [31:0]            entry
);

    logic [31:0]        lane_reg [4];
    logic [31:0]        next_word;
    logic signed [64:0] product;
    logic [31:0]        entry_reg;

    // A step advances the selected lane; over a group of four steps every
    // lane moves once, which matches advancing all four per group.
    assign next_word = xs32(lane_reg[ctrl.lane]);
    assign product   = $signed({{33{next_word[31]}}, next_word}) * $signed({33'd0, scale});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                lane_reg[i] <= RESET_LANE_WORD;
            end
        end
        else if (cfg_write && cfg_index == REG_SEED_LOW_LANES)
        begin
            lane_reg[0] <= cfg_data[31:0];
            lane_reg[1] <= cfg_data[63:32];
        end
        else if (cfg_write && cfg_index == REG_SEED_HIGH_LANES)
        begin
            lane_reg[2] <= cfg_data[31:0];
            lane_reg[3] <= cfg_data[63:32];
        end
        else if (ctrl.step)
        begin
            lane_reg[ctrl.lane] <= next_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            entry_reg <= product[63:32];
        end
    end

    assign entry = entry_reg;

endmodule

### hw/rtl/audio_xorshift_dither_unit.sv
// ----------------------------------------------------------------------------
// Audio xorshift dither unit
// Fills a dither table from four xorshift32 lanes, then adds table entries to
// planar Q1.30 samples with saturation; samples outside a block pass unchanged.
// ----------------------------------------------------------------------------
// A sample's result is registered in the read stage, then in the output register.
// Throughput: one sample per cycle while no fill runs and the output is not stalled;
// the table read and the output register form a two-stage path.
// A block start fills R entries, R = min(block length, table length clamped to
// 4 .. table depth) rounded up to a multiple of four: the table memory's single write
// port takes one entry per cycle, and a drain state follows for the last write.
// Reset clears the control state and sets every lane to 1; the table has no
// clearing pass and holds whatever it held until a fill writes it.
module audio_xorshift_dither_unit import axd_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    axd_in_if.sink                 in_ch,
    axd_out_if.source              out_ch
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 4);

    // Configuration registers.
    logic [31:0] scale_reg;
    logic [10:0] table_length_reg;
    logic [6:0]  channel_count_reg;

    // Control state.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic [CNT_W-1:0] fill_end_reg, fill_end_next;
    logic             wr_pending_reg, wr_pending_next;
    logic [CNT_W-1:0] wr_addr_reg, wr_addr_next;
    logic             block_open_reg, block_open_next;
    logic [15:0]      position_reg, position_next;
    logic [15:0]      block_len_reg, block_len_next;
    logic [5:0]       channel_reg, channel_next;
    logic [IDX_W-1:0] table_idx_reg, table_idx_next;
    logic [CNT_W-1:0] latched_len_reg, latched_len_next;
    logic [6:0]       latched_ch_reg, latched_ch_next;

    // Read stage and output register.
    logic             s1_valid_reg, s1_valid_next;
    logic [31:0]      s1_sample_reg, s1_sample_next;
    logic             s1_last_reg, s1_last_next;
    logic             s1_outside_reg, s1_outside_next;
    logic             out_valid_reg, out_valid_next;
    out_payload_t     out_data_reg, out_data_next;

    noise_ctrl_t      noise_ctrl;
    logic [31:0]      noise_entry;
    logic             rd_en;
    logic [31:0]      rd_data;
    logic             mem_we;

    logic             out_free;
    logic             s1_advance;
    logic             in_accept;

    logic [31:0]      tl_wide, len_eff, count_wide, end_wide;
    logic [6:0]       ch_eff;
    logic [16:0]      position_inc;
    logic [6:0]       channel_inc;
    logic [CNT_W-1:0] idx_inc;
    logic signed [32:0] sum_wide;
    logic [31:0]      sat_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg         <= RESET_SCALE;
            table_length_reg  <= RESET_TABLE_LENGTH;
            channel_count_reg <= RESET_CHANNEL_COUNT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SCALE:         scale_reg         <= cfg_data[31:0];
                REG_TABLE_LENGTH:  table_length_reg  <= cfg_data[10:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[6:0];
                default:           ;
            endcase
        end
    end

    axd_noise_gen u_noise_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scale     (scale_reg),
        .ctrl      (noise_ctrl),
        .entry     (noise_entry)
    );

    assign mem_we = wr_pending_reg && (wr_addr_reg < CNT_W'(TABLE_DEPTH));

    axd_table_mem #(
        .DEPTH (TABLE_DEPTH)
    ) u_table_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (wr_addr_reg[IDX_W-1:0]),
        .wr_data (noise_entry),
        .rd_en   (rd_en),
        .rd_addr (table_idx_reg),
        .rd_data (rd_data)
    );

    assign out_free   = !out_valid_reg || out_ch.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ch.ready = (state_reg == ST_IDLE) && (!s1_valid_reg || out_free);
    assign in_accept  = in_ch.valid && in_ch.ready;

    // Effective lengths for a block start, in a wide domain before truncation.
    always_comb
    begin
        tl_wide = 32'(table_length_reg);
        if (tl_wide < 32'd4)
        begin
            len_eff = 32'd4;
        end
        else if (tl_wide > 32'(TABLE_DEPTH))
        begin
            len_eff = 32'(TABLE_DEPTH);
        end
        else
        begin
            len_eff = tl_wide;
        end
        count_wide = (32'(in_ch.data.block_length) < len_eff)
                   ? 32'(in_ch.data.block_length) : len_eff;
        end_wide   = (count_wide + 32'd3) & ~32'd3;

        if (channel_count_reg == 7'd0)
        begin
            ch_eff = 7'd1;
        end
        else if (channel_count_reg > MAX_CHANNELS)
        begin
            ch_eff = MAX_CHANNELS;
        end
        else
        begin
            ch_eff = channel_count_reg;
        end
    end

    assign position_inc = {1'b0, position_reg} + 17'd1;
    assign channel_inc  = {1'b0, channel_reg} + 7'd1;
    assign idx_inc      = CNT_W'(table_idx_reg) + CNT_W'(1);

    assign sum_wide = $signed({s1_sample_reg[31], s1_sample_reg})
                    + $signed({rd_data[31], rd_data});

    always_comb
    begin
        if (sum_wide[32] != sum_wide[31])
        begin
            sat_sum = sum_wide[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            sat_sum = sum_wide[31:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        fill_cnt_next    = fill_cnt_reg;
        fill_end_next    = fill_end_reg;
        wr_pending_next  = 1'b0;
        wr_addr_next     = wr_addr_reg;
        block_open_next  = block_open_reg;
        position_next    = position_reg;
        block_len_next   = block_len_reg;
        channel_next     = channel_reg;
        table_idx_next   = table_idx_reg;
        latched_len_next = latched_len_reg;
        latched_ch_next  = latched_ch_reg;
        s1_valid_next    = s1_valid_reg && !s1_advance;
        s1_sample_next   = s1_sample_reg;
        s1_last_next     = s1_last_reg;
        s1_outside_next  = s1_outside_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_data_next    = out_data_reg;
        noise_ctrl.step  = 1'b0;
        noise_ctrl.lane  = fill_cnt_reg[1:0];
        rd_en            = 1'b0;

        if (s1_advance)
        begin
            out_valid_next                = 1'b1;
            out_data_next.dithered_sample = s1_outside_reg ? s1_sample_reg : sat_sum;
            out_data_next.last_of_block   = s1_last_reg;
            out_data_next.outside_block   = s1_outside_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && in_ch.data.kind == KIND_BLOCK_START)
                begin
                    latched_len_next = len_eff[CNT_W-1:0];
                    latched_ch_next  = ch_eff;
                    block_len_next   = in_ch.data.block_length;
                    position_next    = 16'd0;
                    channel_next     = 6'd0;
                    table_idx_next   = '0;
                    block_open_next  = in_ch.data.block_length != 16'd0;
                    fill_cnt_next    = '0;
                    fill_end_next    = end_wide[CNT_W-1:0];
                    if (in_ch.data.block_length != 16'd0)
                    begin
                        state_next = ST_FILL;
                    end
                end
                else if (in_accept)
                begin
                    s1_valid_next   = 1'b1;
                    s1_sample_next  = in_ch.data.sample;
                    s1_outside_next = !block_open_reg;
                    s1_last_next    = block_open_reg
                                   && (position_inc == {1'b0, block_len_reg})
                                   && (channel_inc == latched_ch_reg);
                    if (block_open_reg)
                    begin
                        rd_en = 1'b1;
                        if (position_inc >= {1'b0, block_len_reg})
                        begin
                            position_next  = 16'd0;
                            table_idx_next = '0;
                            if (channel_inc >= latched_ch_reg)
                            begin
                                channel_next    = 6'd0;
                                block_open_next = 1'b0;
                            end
                            else
                            begin
                                channel_next = channel_inc[5:0];
                            end
                        end
                        else
                        begin
                            position_next  = position_inc[15:0];
                            table_idx_next = (idx_inc == latched_len_reg)
                                           ? '0 : idx_inc[IDX_W-1:0];
                        end
                    end
                end
            end

            ST_FILL:
            begin
                // One entry per cycle; the scaled word is written in the following cycle.
                noise_ctrl.step = 1'b1;
                wr_pending_next = 1'b1;
                wr_addr_next    = fill_cnt_reg;
                fill_cnt_next   = fill_cnt_reg + CNT_W'(1);
                if (fill_cnt_next == fill_end_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fill_cnt_reg    <= '0;
            fill_end_reg    <= '0;
            wr_pending_reg  <= 1'b0;
            block_open_reg  <= 1'b0;
            position_reg    <= 16'd0;
            block_len_reg   <= 16'd0;
            channel_reg     <= 6'd0;
            table_idx_reg   <= '0;
            latched_len_reg <= CNT_W'(TABLE_DEPTH);
            latched_ch_reg  <= 7'd1;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fill_cnt_reg    <= fill_cnt_next;
            fill_end_reg    <= fill_end_next;
            wr_pending_reg  <= wr_pending_next;
            block_open_reg  <= block_open_next;
            position_reg    <= position_next;
            block_len_reg   <= block_len_next;
            channel_reg     <= channel_next;
            table_idx_reg   <= table_idx_next;
            latched_len_reg <= latched_len_next;
            latched_ch_reg  <= latched_ch_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg    <= wr_addr_next;
        s1_sample_reg  <= s1_sample_next;
        s1_last_reg    <= s1_last_next;
        s1_outside_reg <= s1_outside_next;
        out_data_reg   <= out_data_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule
